// ===== rtl/bca_pkg.sv =====
// Shared types, constants and helper functions of the bitmap allocator.
`default_nettype none
package bca_pkg;

    // Map geometry
    localparam int MAP_BITS  = 32768;
    localparam int MAP_AW    = $clog2(MAP_BITS);
    localparam int WORD_W    = 64;
    localparam int WORD_AW   = $clog2(WORD_W);
    localparam int MAP_WORDS = MAP_BITS / WORD_W;
    localparam int WAW       = $clog2(MAP_WORDS);
    localparam int RUN_W     = MAP_AW + 1;

    // Field widths
    localparam int DIV_W   = 32;
    localparam int BYTES_W = 40;
    localparam int PROD_W  = MAP_AW + DIV_W;

    localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

    // Result status codes
    localparam logic [2:0] ST_GRANTED  = 3'd0;
    localparam logic [2:0] ST_NOSPACE  = 3'd1;
    localparam logic [2:0] ST_FREED    = 3'd2;
    localparam logic [2:0] ST_NOTPOOL  = 3'd3;
    localparam logic [2:0] ST_DISABLED = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_BPB      = 2'd0;
    localparam logic [1:0] CFG_POOL     = 2'd1;
    localparam logic [1:0] CFG_DISABLED = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_MARK_RD,
        S_MARK_WR,
        S_REC,
        S_MULA,
        S_MULB,
        S_MULC,
        S_DONE
    } state_t;

    // Number of free bits from bit 0 upwards
    function automatic logic [WORD_AW:0] low_free(input logic [WORD_W-1:0] f);
        logic [WORD_AW:0] c;
        logic             stop;
        c    = '0;
        stop = 1'b0;
        for (int k = 0; k < WORD_W; k++)
        begin
            if (!stop && f[k])
                c = c + 1'b1;
            else
                stop = 1'b1;
        end
        return c;
    endfunction

    // Number of free bits from the top bit downwards
    function automatic logic [WORD_AW:0] high_free(input logic [WORD_W-1:0] f);
        logic [WORD_AW:0] c;
        logic             stop;
        c    = '0;
        stop = 1'b0;
        for (int k = WORD_W - 1; k >= 0; k--)
        begin
            if (!stop && f[k])
                c = c + 1'b1;
            else
                stop = 1'b1;
        end
        return c;
    endfunction

    // Start positions of free windows of length len inside one word (doubling steps)
    function automatic logic [WORD_W-1:0] win_ok(input logic [WORD_W-1:0] f,
                                                 input logic [WORD_AW:0] len);
        logic [WORD_W-1:0] r;
        logic [WORD_W-1:0] acc;
        logic [WORD_AW+1:0] off;
        r   = f;
        acc = '1;
        off = '0;
        for (int b = 0; b <= WORD_AW; b++)
        begin
            if (len[b])
            begin
                acc = acc & (r >> off);
                off = off + (WORD_AW+2)'(1 << b);
            end
            r = r & (r >> (1 << b));
        end
        return acc;
    endfunction

    // Lowest set bit position
    function automatic logic [WORD_AW-1:0] low_set(input logic [WORD_W-1:0] v);
        logic [WORD_AW-1:0] p;
        p = '0;
        for (int k = WORD_W - 1; k >= 0; k--)
        begin
            if (v[k])
                p = WORD_AW'(k);
        end
        return p;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/bca_div.sv =====
// Restoring serial divider: one quotient bit per cycle.
`default_nettype none
module bca_div
(
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        start,
    input  wire [bca_pkg::DIV_W-1:0]   dividend,
    input  wire [bca_pkg::DIV_W-1:0]   divisor,
    output logic                       done,
    output logic [bca_pkg::DIV_W-1:0]  quot,
    output logic [bca_pkg::DIV_W-1:0]  rem
);
    import bca_pkg::*;

    localparam int CW = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             fits;

    // One trial subtraction a cycle
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire

// ===== rtl/bitmap_contiguous_allocator_top.sv =====
// Bitmap first-fit allocator: sequencer, bitmap and run-length memories, shared multiplier.
// Reset: a clearing pass zeroes both memories; no transfer is taken meanwhile.
// Allocate: the serial divider, then a word-by-word scan through the bitmap memory
// read port, then a read and a write per marked word, then the multiply steps.
// Free: a read and write per cleared word, then multiplies. Disabled/refused: to result.
// One request is worked on at a time; the next may be taken while the result waits.
`default_nettype none
module bitmap_contiguous_allocator_top
(
    input  wire         clk,
    input  wire         rst_n,
    // Configuration write port
    input  wire         cfg_we,
    input  wire  [1:0]  cfg_addr,
    input  wire  [39:0] cfg_wdata,
    // Requests
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] size_bytes, [46:32] start_bit, [47] given_len_valid, [62:48] given_len
    input  wire  [63:0] s_axis_tdata,
    // [0] req_type
    input  wire  [0:0]  s_axis_tuser,
    // Results
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [14:0] alloc_start_bit, [54:15] byte_offset, [94:55] bytes_left
    output logic [95:0] m_axis_tdata,
    // [2:0] status
    output logic [2:0]  m_axis_tuser
);
    import bca_pkg::*;

    state_t state_reg, state_next;

    // Configuration
    logic [DIV_W-1:0]   bpb_reg;
    logic               dis_reg;
    logic [BYTES_W-1:0] remain_reg;

    // Request fields
    logic [MAP_AW-1:0] start_reg;
    logic [MAP_AW-1:0] len_reg;
    logic [MAP_AW-1:0] hi_reg;
    logic              free_reg;

    // Scan
    logic [WAW:0]      rd_ptr_reg;
    logic [WAW-1:0]    ev_ptr_reg;
    logic              dv_reg;
    logic [RUN_W-1:0]  run_reg;
    logic [WAW-1:0]    mk_ptr_reg;
    logic [MAP_AW-1:0] clr_reg;

    // Result
    logic [2:0]         res_st_reg;
    logic [MAP_AW-1:0]  res_sb_reg;
    logic [BYTES_W-1:0] res_off_reg;
    logic [PROD_W-1:0]  prod_reg;

    // Memories
    logic [WORD_W-1:0] map_mem [MAP_WORDS];
    logic [MAP_AW-1:0] rec_mem [MAP_BITS];
    logic [WORD_W-1:0] map_q;
    logic [MAP_AW-1:0] rec_q;
    logic              map_re, map_we, rec_we;
    logic [WAW-1:0]    map_ra, map_wa;
    logic [WORD_W-1:0] map_wd;
    logic [MAP_AW-1:0] rec_wa, rec_wd;

    // Input fields
    logic [DIV_W-1:0]  in_size;
    logic [MAP_AW-1:0] in_start, in_glen;
    logic              in_glv, in_free, in_acc;

    assign in_size  = s_axis_tdata[31:0];
    assign in_start = s_axis_tdata[46:32];
    assign in_glv   = s_axis_tdata[47];
    assign in_glen  = s_axis_tdata[62:48];
    assign in_free  = s_axis_tuser[0];
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc   = s_axis_tvalid && s_axis_tready;

    // Divider for the bit count, started on the accepting edge
    logic             div_start, div_done;
    logic [DIV_W-1:0] div_q, div_r;
    logic [DIV_W+1:0] n_full;

    assign div_start = in_acc && !dis_reg && !in_free
                       && ({8'd0, in_size} <= remain_reg) && (bpb_reg != '0);

    bca_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (in_size),
        .divisor  (bpb_reg),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    // n = 1 + q + (2r >= bpb)
    assign n_full = (DIV_W+2)'(div_q) + (DIV_W+2)'(1)
                    + (DIV_W+2)'({div_r, 1'b0} >= {1'b0, bpb_reg});

    // Word evaluation during the scan
    logic [WORD_W-1:0] fr;
    logic [WORD_AW:0]  lowf, highf;
    logic [RUN_W:0]    need;
    logic [RUN_W+1:0]  pre_sum;
    logic              pre_hit, win_hit;
    logic [WORD_W-1:0] wins;
    logic [MAP_AW-1:0] base, found_start;
    logic [RUN_W-1:0]  run_new;
    logic [RUN_W:0]    run_add;

    assign fr      = ~map_q;
    assign lowf    = low_free(fr);
    assign highf   = high_free(fr);
    assign need    = (RUN_W+1)'(len_reg) + (RUN_W+1)'(1);
    assign pre_sum = (RUN_W+2)'(run_reg) + (RUN_W+2)'(lowf);
    assign pre_hit = pre_sum >= (RUN_W+2)'(need);
    assign wins    = win_ok(fr, need[WORD_AW:0]);
    assign win_hit = (need <= (RUN_W+1)'(WORD_W)) && (wins != '0);
    assign base    = {ev_ptr_reg, {WORD_AW{1'b0}}};
    assign found_start = pre_hit ? base - run_reg[MAP_AW-1:0]
                                 : base + MAP_AW'(low_set(wins));
    assign run_add = (RUN_W+1)'(run_reg) + (RUN_W+1)'(WORD_W);
    assign run_new = (map_q == '0)
                     ? ((run_add > (RUN_W+1)'(MAP_BITS)) ? RUN_W'(MAP_BITS)
                                                         : run_add[RUN_W-1:0])
                     : RUN_W'(highf);

    // Mark / clear mask for the current word
    logic [WORD_AW-1:0] lo_b, hi_b;
    logic [WORD_W-1:0]  mask;

    assign lo_b = (mk_ptr_reg == start_reg[MAP_AW-1:WORD_AW]) ? start_reg[WORD_AW-1:0] : '0;
    assign hi_b = (mk_ptr_reg == hi_reg[MAP_AW-1:WORD_AW]) ? hi_reg[WORD_AW-1:0] : '1;
    assign mask = ({WORD_W{1'b1}} << lo_b) & ({WORD_W{1'b1}} >> (~hi_b));

    // Free run end, clamped to the map
    logic [MAP_AW:0]   free_len_sel;
    logic [MAP_AW:0]   free_end;
    logic [MAP_AW-1:0] free_hi;

    assign free_end = (MAP_AW+1)'(start_reg) + (MAP_AW+1)'(len_reg);
    assign free_hi  = (free_end >= (MAP_AW+1)'(MAP_BITS)) ? MAP_AW'(MAP_BITS - 1)
                                                          : free_end[MAP_AW-1:0];
    assign free_len_sel = (MAP_AW+1)'(rec_q);

    // Shared multiplier and counter arithmetic
    logic [MAP_AW-1:0]  mul_a;
    logic [PROD_W-1:0]  mul_p;
    logic [PROD_W:0]    add_sum;
    logic [BYTES_W-1:0] remain_sub, remain_add, off_sat;

    assign mul_a      = (state_reg == S_MULB) ? start_reg : len_reg;
    assign mul_p      = PROD_W'(mul_a) * PROD_W'(bpb_reg);
    assign remain_sub = (prod_reg > PROD_W'(remain_reg)) ? '0
                        : remain_reg - prod_reg[BYTES_W-1:0];
    assign add_sum    = (PROD_W+1)'(prod_reg) + (PROD_W+1)'(remain_reg);
    assign remain_add = (add_sum > (PROD_W+1)'(BYTES_MAX)) ? BYTES_MAX
                                                           : add_sum[BYTES_W-1:0];
    assign off_sat    = (prod_reg > PROD_W'(BYTES_MAX)) ? BYTES_MAX : prod_reg[BYTES_W-1:0];

    // Next state and memory port control
    always_comb
    begin
        state_next = state_reg;
        map_re = 1'b0;
        map_ra = '0;
        map_we = 1'b0;
        map_wa = mk_ptr_reg;
        map_wd = free_reg ? (map_q & ~mask) : (map_q | mask);
        rec_we = 1'b0;
        rec_wa = start_reg;
        rec_wd = free_reg ? '0 : len_reg;
        case (state_reg)
            S_CLEAR:
            begin
                map_we = (clr_reg[MAP_AW-1:WAW] == '0);
                map_wa = clr_reg[WAW-1:0];
                map_wd = '0;
                rec_we = 1'b1;
                rec_wa = clr_reg;
                rec_wd = '0;
                if (clr_reg == MAP_AW'(MAP_BITS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (dis_reg)
                        state_next = S_DONE;
                    else if (!in_free)
                        state_next = div_start ? S_DIV : S_DONE;
                    else if ((MAP_AW+1)'(in_start) >= (MAP_AW+1)'(MAP_BITS))
                        state_next = S_DONE;
                    else if (in_glv)
                        state_next = (in_glen == '0) ? S_DONE : S_MARK_RD;
                    else
                        state_next = S_REC;
                end
            end
            S_REC:
                state_next = (free_len_sel == '0) ? S_DONE : S_MARK_RD;
            S_DIV:
            begin
                if (div_done)
                    state_next = (n_full >= (DIV_W+2)'(MAP_BITS)) ? S_DONE : S_SCAN;
            end
            S_SCAN:
            begin
                map_re = (rd_ptr_reg < (WAW+1)'(MAP_WORDS));
                map_ra = rd_ptr_reg[WAW-1:0];
                if (dv_reg)
                begin
                    if (pre_hit || win_hit)
                        state_next = S_MARK_RD;
                    else if (ev_ptr_reg == WAW'(MAP_WORDS - 1))
                        state_next = S_DONE;
                end
            end
            S_MARK_RD:
            begin
                map_re = 1'b1;
                map_ra = mk_ptr_reg;
                state_next = S_MARK_WR;
            end
            S_MARK_WR:
            begin
                map_we = 1'b1;
                if (mk_ptr_reg == hi_reg[MAP_AW-1:WORD_AW])
                begin
                    rec_we = 1'b1;
                    state_next = S_MULA;
                end
                else
                    state_next = S_MARK_RD;
            end
            S_MULA:
                state_next = S_MULB;
            S_MULB:
                state_next = free_reg ? S_DONE : S_MULC;
            S_MULC:
                state_next = S_DONE;
            S_DONE:
            begin
                if (!m_axis_tvalid || m_axis_tready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    // Memories
    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[map_wa] <= map_wd;
        if (map_re)
            map_q <= map_mem[map_ra];
    end

    always_ff @(posedge clk)
    begin
        if (rec_we)
            rec_mem[rec_wa] <= rec_wd;
        rec_q <= rec_mem[in_start];
    end

    // Configuration and byte counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpb_reg    <= DIV_W'(4096);
            dis_reg    <= 1'b0;
            remain_reg <= BYTES_W'(134217728);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_BPB:      bpb_reg    <= cfg_wdata[DIV_W-1:0];
                CFG_POOL:     remain_reg <= cfg_wdata;
                CFG_DISABLED: dis_reg    <= cfg_wdata[0];
                default:      ;
            endcase
        end
        else if (state_reg == S_MULB)
            remain_reg <= free_reg ? remain_add : remain_sub;
    end

    // Control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg    <= '0;
            rd_ptr_reg <= '0;
            dv_reg     <= 1'b0;
            run_reg    <= '0;
        end
        else
        begin
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (state_reg == S_DIV)
            begin
                rd_ptr_reg <= '0;
                dv_reg     <= 1'b0;
                run_reg    <= '0;
            end
            else if (state_reg == S_SCAN)
            begin
                dv_reg <= map_re;
                if (map_re)
                    rd_ptr_reg <= rd_ptr_reg + 1'b1;
                if (dv_reg)
                    run_reg <= run_new;
            end
        end
    end

    // Request datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == S_SCAN && map_re)
            ev_ptr_reg <= rd_ptr_reg[WAW-1:0];
        if (state_reg == S_MULA || state_reg == S_MULB)
            prod_reg <= mul_p;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    free_reg    <= in_free;
                    start_reg   <= in_start;
                    len_reg     <= in_glen;
                    res_sb_reg  <= '0;
                    res_off_reg <= '0;
                    mk_ptr_reg  <= in_start[MAP_AW-1:WORD_AW];
                    if (dis_reg)
                        res_st_reg <= ST_DISABLED;
                    else if (in_free)
                        res_st_reg <= ST_NOTPOOL;
                    else
                        res_st_reg <= ST_NOSPACE;
                end
            end
            S_REC:
                len_reg <= rec_q;
            S_DIV:
                len_reg <= n_full[MAP_AW-1:0];
            S_SCAN:
            begin
                if (dv_reg && (pre_hit || win_hit))
                begin
                    start_reg  <= found_start;
                    mk_ptr_reg <= found_start[MAP_AW-1:WORD_AW];
                    hi_reg     <= found_start + len_reg;
                end
            end
            S_MARK_RD:
            begin
                if (free_reg)
                    hi_reg <= free_hi;
            end
            S_MARK_WR:
                mk_ptr_reg <= mk_ptr_reg + 1'b1;
            S_MULB:
            begin
                if (free_reg)
                    res_st_reg <= ST_FREED;
            end
            S_MULC:
            begin
                res_st_reg  <= ST_GRANTED;
                res_sb_reg  <= start_reg;
                res_off_reg <= off_sat;
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tvalid <= 1'b0;
        else if (state_reg == S_DONE && (!m_axis_tvalid || m_axis_tready))
            m_axis_tvalid <= 1'b1;
        else if (m_axis_tready)
            m_axis_tvalid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && (!m_axis_tvalid || m_axis_tready))
        begin
            m_axis_tuser <= res_st_reg;
            m_axis_tdata <= {1'b0, remain_reg, res_off_reg, res_sb_reg};
        end
    end

    // Checks
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_axis_tready)
        else $error("request taken while another is in work");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_GRANTED) |->
            (m_axis_tdata[54:0] == '0))
        else $error("non-granted result carries start or offset");

    a_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (map_we && map_re) |-> (state_reg == S_CLEAR))
        else $error("bitmap read and write in the same cycle");

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !m_axis_tvalid)
        else $error("result during clearing pass");

endmodule
`default_nettype wire
